// File: design/raccel_pkg.sv
`timescale 1ns / 1ps

package raccel_pkg;

   localparam int POS_W      = 16;
   localparam int STEP_W     = 8;
   localparam int MS_W       = 16;
   localparam int TIME_W     = 32;
   localparam int WIDE_W     = POS_W + 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // request kinds
   localparam logic REQ_EVENT = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_POSITION   = 3'd0,
      CSR_MAX_POSITION   = 3'd1,
      CSR_SLOW_STEP      = 3'd2,
      CSR_FAST_STEP      = 3'd3,
      CSR_WRAP_ENABLE    = 3'd4,
      CSR_FAST_WINDOW_MS = 3'd5,
      CSR_LONG_PRESS_MS  = 3'd6
   } csr_index_type;

   localparam logic signed [POS_W-1:0] MIN_POSITION_RST   = -16'sd32767;
   localparam logic signed [POS_W-1:0] MAX_POSITION_RST   = 16'sd32766;
   localparam logic [STEP_W-1:0]       SLOW_STEP_RST      = 8'd1;
   localparam logic [STEP_W-1:0]       FAST_STEP_RST      = 8'd2;
   localparam logic                    WRAP_ENABLE_RST    = 1'b0;
   localparam logic [MS_W-1:0]         FAST_WINDOW_MS_RST = 16'd300;
   localparam logic [MS_W-1:0]         LONG_PRESS_MS_RST  = 16'd1000;

   typedef struct packed {
      logic signed [POS_W-1:0] min_position;
      logic signed [POS_W-1:0] max_position;
      logic [STEP_W-1:0]       slow_step;
      logic [STEP_W-1:0]       fast_step;
      logic                    wrap_enable;
      logic [MS_W-1:0]         fast_window_ms;
      logic [MS_W-1:0]         long_press_ms;
   } cfg_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic                    armed;
      logic [TIME_W-1:0]       low_start_time;
      logic [TIME_W-1:0]       last_move_time;
      logic                    direction;
   } state_type;

   typedef struct packed {
      logic                    req_type;
      logic                    a_level;
      logic                    b_level;
      logic [TIME_W-1:0]       now_ms;
      logic signed [POS_W-1:0] write_value;
   } req_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic                    moved;
      logic                    write_accepted;
   } rsp_item_type;

endpackage

// File: design/raccel_if.sv
`timescale 1ns / 1ps

interface raccel_req_if import raccel_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic                    a_level;
   logic                    b_level;
   logic [TIME_W-1:0]       now_ms;
   logic signed [POS_W-1:0] write_value;

   modport source (output valid, req_type, a_level, b_level, now_ms, write_value,
                   input ready);
   modport sink   (input valid, req_type, a_level, b_level, now_ms, write_value,
                   output ready);
endinterface

interface raccel_rsp_if import raccel_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] position;
   logic                    moved;
   logic                    write_accepted;

   modport source (output valid, position, moved, write_accepted, input ready);
   modport sink   (input valid, position, moved, write_accepted, output ready);
endinterface

interface raccel_csr_if import raccel_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/raccel_csr.sv
`timescale 1ns / 1ps

module raccel_csr import raccel_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(wr_index))
            CSR_MIN_POSITION:   cfg_in.min_position   = $signed(wr_data[POS_W-1:0]);
            CSR_MAX_POSITION:   cfg_in.max_position   = $signed(wr_data[POS_W-1:0]);
            CSR_SLOW_STEP:      cfg_in.slow_step      = wr_data[STEP_W-1:0];
            CSR_FAST_STEP:      cfg_in.fast_step      = wr_data[STEP_W-1:0];
            CSR_WRAP_ENABLE:    cfg_in.wrap_enable    = wr_data[0];
            CSR_FAST_WINDOW_MS: cfg_in.fast_window_ms = wr_data[MS_W-1:0];
            CSR_LONG_PRESS_MS:  cfg_in.long_press_ms  = wr_data[MS_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_position   <= MIN_POSITION_RST;
         cfg_ff.max_position   <= MAX_POSITION_RST;
         cfg_ff.slow_step      <= SLOW_STEP_RST;
         cfg_ff.fast_step      <= FAST_STEP_RST;
         cfg_ff.wrap_enable    <= WRAP_ENABLE_RST;
         cfg_ff.fast_window_ms <= FAST_WINDOW_MS_RST;
         cfg_ff.long_press_ms  <= LONG_PRESS_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/raccel_update.sv
`timescale 1ns / 1ps

module raccel_update import raccel_pkg::*; (
   input  cfg_type      cfg,
   input  state_type    state,
   input  req_item_type item,
   output state_type    state_nxt,
   output rsp_item_type result
);

   logic [TIME_W-1:0]        low_age;
   logic [TIME_W-1:0]        move_age;
   logic                     long_low;
   logic                     rearm_late;
   logic [STEP_W-1:0]        fast_eff;
   logic [STEP_W-1:0]        step;
   logic signed [WIDE_W-1:0] step_w;
   logic signed [WIDE_W-1:0] pos_w;
   logic signed [WIDE_W-1:0] min_w;
   logic signed [WIDE_W-1:0] max_w;
   logic signed [WIDE_W-1:0] sum;
   logic signed [WIDE_W-1:0] clamp_hi;
   logic signed [WIDE_W-1:0] clamp_lo;
   logic                     in_bounds;

   always_comb begin
      low_age    = item.now_ms - state.low_start_time;
      move_age   = item.now_ms - state.last_move_time;
      long_low   = low_age >= TIME_W'(cfg.long_press_ms);
      rearm_late = low_age > TIME_W'(cfg.long_press_ms);

      fast_eff = (cfg.fast_step > cfg.slow_step) ? cfg.fast_step : cfg.slow_step;
      step     = (move_age < TIME_W'(cfg.fast_window_ms)) ? fast_eff : cfg.slow_step;

      // wide add so nothing wraps at the position width
      step_w = $signed({{(WIDE_W-STEP_W){1'b0}}, step});
      pos_w  = WIDE_W'(state.position);
      min_w  = WIDE_W'(cfg.min_position);
      max_w  = WIDE_W'(cfg.max_position);
      sum    = state.direction ? (pos_w - step_w) : (pos_w + step_w);

      // upper bound first, then lower bound on the adjusted value
      clamp_hi = (sum > max_w) ? (cfg.wrap_enable ? min_w : max_w) : sum;
      clamp_lo = (clamp_hi < min_w) ? (cfg.wrap_enable ? max_w : min_w) : clamp_hi;

      in_bounds = (item.write_value >= cfg.min_position) &&
                  (item.write_value <= cfg.max_position);

      state_nxt             = state;
      result.moved          = 1'b0;
      result.write_accepted = 1'b0;

      case (item.req_type)
         REQ_WRITE: begin
            if (in_bounds) begin
               state_nxt.position    = item.write_value;
               result.write_accepted = 1'b1;
            end
         end
         REQ_EVENT: begin
            if (!item.a_level) begin
               if (!state.armed || rearm_late) begin
                  state_nxt.armed          = 1'b1;
                  state_nxt.low_start_time = item.now_ms;
                  state_nxt.direction      = item.b_level;
               end
            end else if (state.armed) begin
               if (!long_low) begin
                  state_nxt.last_move_time = item.now_ms;
                  state_nxt.position       = clamp_lo[POS_W-1:0];
                  result.moved             = 1'b1;
               end
               state_nxt.armed = 1'b0;
            end
         end
         default: state_nxt = state;
      endcase

      result.position = state_nxt.position;
   end

endmodule

// File: design/rotary_encoder_accel_counter_core.sv
`timescale 1ns / 1ps

// Rotary encoder position counter with acceleration.
//
// req_ch carries one item per transfer: a channel A level change (with the
// B level and a millisecond timestamp) or a position write. rsp_ch returns
// exactly one result per item: the position after the item, whether a step
// was applied, and whether a write was taken. csr_ch writes the seven
// configuration registers by index; it is always ready and should only be
// used while no item is in flight.
//
// An item is held in the input register and moves to the result register
// once that register is free or draining; its result is then offered on
// rsp_ch. Throughput is one item per cycle while rsp_ch does not stall; the
// only recurrence is the position/arming state, updated in one pass as an
// item moves to the result register.
//
// Reset clears both pipeline valids, the position and the arming/timing
// state, and loads the register defaults. When rsp_ch stalls, the result is
// held; one more item may wait in the input register, then req_ch backs up.

module rotary_encoder_accel_counter_core import raccel_pkg::*; (
   input  logic clock,
   input  logic reset,
   raccel_req_if.sink   req_ch,
   raccel_rsp_if.source rsp_ch,
   raccel_csr_if.sink   csr_ch
);

   cfg_type      cfg;
   state_type    state_ff;
   state_type    state_in;
   state_type    state_nxt;
   req_item_type req_item;
   req_item_type in_item_ff;
   req_item_type in_item_in;
   rsp_item_type rsp_item;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;
   logic         in_valid_ff;
   logic         in_valid_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   logic         advance;
   logic         req_xfer;

   // configuration registers
   raccel_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );
   assign csr_ch.ready = 1'b1;

   // gather the request payload
   assign req_item.req_type    = req_ch.req_type;
   assign req_item.a_level     = req_ch.a_level;
   assign req_item.b_level     = req_ch.b_level;
   assign req_item.now_ms      = req_ch.now_ms;
   assign req_item.write_value = req_ch.write_value;

   // advance the held item when the result register is free or draining
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   raccel_update u_update (
      .cfg       (cfg),
      .state     (state_ff),
      .item      (in_item_ff),
      .state_nxt (state_nxt),
      .result    (rsp_item)
   );

   always_comb begin
      in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in   = req_xfer ? req_item : in_item_ff;
      // drop the result once taken, unless a new one replaces it
      out_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      out_item_in  = advance ? rsp_item : out_item_ff;
      state_in     = advance ? state_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
         state_ff.position       <= '0;
         state_ff.armed          <= 1'b0;
         state_ff.low_start_time <= '0;
         state_ff.last_move_time <= '0;
         state_ff.direction      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.position       = out_item_ff.position;
   assign rsp_ch.moved          = out_item_ff.moved;
   assign rsp_ch.write_accepted = out_item_ff.write_accepted;

`ifndef NO_ASSERTIONS
   // a result never reports both a step and a taken write
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_item_ff.moved && out_item_ff.write_accepted))
      else $error("result flags both moved and write_accepted");

   // the counter state only changes when an item moves to the result register
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without an item advancing");

   // a step always disarms
   assert property (@(posedge clock) disable iff (reset)
      advance && rsp_item.moved |=> !state_ff.armed)
      else $error("block still armed after a step");

   // a taken write lies inside the bounds
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.write_accepted |->
         (out_item_ff.position >= cfg.min_position) &&
         (out_item_ff.position <= cfg.max_position))
      else $error("accepted write outside bounds");
`endif

endmodule
